// ===== hw/rtl/tlpq_pkg.sv =====
// Shared constants, types and a helper function of the three-level priority queue.
package tlpq_pkg;

    localparam int LEVEL_DEPTH = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int PTR_W       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int LVL_W       = 2;
    localparam int ADDR_W      = LVL_W + PTR_W;
    localparam int RAM_DEPTH   = 1 << ADDR_W;
    localparam int BYTE_W      = 8;
    localparam int TDATA_W     = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam logic [LVL_W-1:0] LVL_NONE = '0;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic show;
    } ctl_t;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] nxt;
        if (p == PTR_W'(LEVEL_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = p + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/tlpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tlpq_ctrl.sv =====
// Request sequencer: takes one request, then holds its result until it is taken.
module tlpq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output tlpq_pkg::ctl_t ctl
);
    import tlpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctl.load   = 1'b0;
        ctl.show   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                m_tvalid = 1'b1;
                ctl.show = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tlpq_datapath.sv =====
// Level pointers, occupancy counters, byte store and result register.
module tlpq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlpq_pkg::ctl_t                  ctl,
    input  logic                            command,
    input  logic [tlpq_pkg::BYTE_W-1:0]     data_in,
    input  logic [tlpq_pkg::LVL_W-1:0]      priority_req,
    output logic [tlpq_pkg::BYTE_W-1:0]     data_out,
    output logic [1:0]                      status,
    output logic [tlpq_pkg::LVL_W-1:0]      served_level
);
    import tlpq_pkg::*;

    logic [PTR_W-1:0] head_reg [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_reg [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_next [NUM_LEVELS];

    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [LVL_W-1:0] served_reg;
    logic [LVL_W-1:0] served_next;
    logic             take_reg;
    logic             take_next;

    logic             ins_full;
    logic [PTR_W-1:0] ins_tail;
    logic             rem_found;
    logic [LVL_W-1:0] rem_lvl;
    logic [PTR_W-1:0] rem_head;
    logic             wr_en;
    logic             rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    always_comb
    begin
        ins_full  = 1'b0;
        ins_tail  = '0;
        rem_found = 1'b0;
        rem_lvl   = LVL_NONE;
        rem_head  = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (priority_req == LVL_W'(i + 1))
            begin
                ins_full = (cnt_reg[i] == CNT_W'(LEVEL_DEPTH));
                ins_tail = tail_reg[i];
            end
        end
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                rem_found = 1'b1;
                rem_lvl   = LVL_W'(i + 1);
                rem_head  = head_reg[i];
            end
        end
    end

    always_comb
    begin
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        status_next = status_reg;
        served_next = served_reg;
        take_next   = take_reg;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            cnt_next[i]  = cnt_reg[i];
        end
        if (ctl.load)
        begin
            take_next   = 1'b0;
            served_next = LVL_NONE;
            if (command == CMD_INSERT)
            begin
                if (priority_req == LVL_NONE)
                begin
                    status_next = ST_IGNORED;
                end
                else if (ins_full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    status_next = ST_OK;
                    served_next = priority_req;
                    wr_en       = 1'b1;
                    for (int i = 0; i < NUM_LEVELS; i++)
                    begin
                        if (priority_req == LVL_W'(i + 1))
                        begin
                            tail_next[i] = ptr_advance(tail_reg[i]);
                            cnt_next[i]  = cnt_reg[i] + CNT_W'(1);
                        end
                    end
                end
            end
            else
            begin
                if (!rem_found)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    status_next = ST_OK;
                    served_next = rem_lvl;
                    take_next   = 1'b1;
                    rd_en       = 1'b1;
                    for (int i = 0; i < NUM_LEVELS; i++)
                    begin
                        if (rem_lvl == LVL_W'(i + 1))
                        begin
                            head_next[i] = ptr_advance(head_reg[i]);
                            cnt_next[i]  = cnt_reg[i] - CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        served_reg <= served_next;
        take_reg   <= take_next;
    end

    assign wr_addr = {priority_req, ins_tail};
    assign rd_addr = {rem_lvl, rem_head};

    tlpq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign data_out     = (ctl.show && take_reg) ? rd_data : '0;
    assign status       = ctl.show ? status_reg : ST_OK;
    assign served_level = ctl.show ? served_reg : LVL_NONE;

endmodule

// ===== hw/rtl/three_level_priority_queue.sv =====
// Top level of the three-level priority queue of bytes.
//
// Requests arrive on the s_ stream: s_tuser is the command (insert or remove),
// s_tdata carries the byte and the priority level. Every request gives exactly
// one result on the m_ stream: m_tuser is the status, m_tdata carries the
// removed byte and the level that was served.
// Level 1 is the highest priority; each level is a circular FIFO held in one
// shared store, with a head pointer, a tail pointer and a count per level.
// A request is taken while the sequencer is idle and its result is shown from
// the next cycle on. The request sequencer takes a new request only after the
// previous result has been delivered, and the store is read through a
// registered read port.
// While the receiver holds m_tready low the result stays stable and s_tready
// stays low. Reset empties all levels; the store contents are not cleared.
module three_level_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_in, [9:8] priority_req, rest zero
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_out, [9:8] served_level, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import tlpq_pkg::*;

    ctl_t              ctl;
    logic [BYTE_W-1:0] data_out;
    logic [1:0]        status;
    logic [LVL_W-1:0]  served_level;

    tlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    tlpq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .command      (s_tuser[0]),
        .data_in      (s_tdata[BYTE_W-1:0]),
        .priority_req (s_tdata[BYTE_W+LVL_W-1:BYTE_W]),
        .data_out     (data_out),
        .status       (status),
        .served_level (served_level)
    );

    assign m_tdata = {{(TDATA_W - BYTE_W - LVL_W){1'b0}}, served_level, data_out};
    assign m_tuser = status;

    // Only one request is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("request taken while a result is pending");

    // A taken request shows its result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("result missing after a request");

    // A failed request neither names a level nor returns a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[BYTE_W+LVL_W-1:0] == '0))
        else $error("failed request reports a level or byte");

    // A successful request always names the level that served it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[BYTE_W+LVL_W-1:BYTE_W] != LVL_NONE))
        else $error("successful request without a level");

endmodule
